### design/poi_pkg.sv
// ----------------------------------------------------------------------------
// poi_pkg
// Shared constants, types and the arctangent table of the odometry integrator.
// ----------------------------------------------------------------------------
package poi_pkg;

  localparam int CordicStepsDefault = 16;
  localparam int AtanEntries        = 30;

  localparam logic signed [33:0] GainQ30    = 34'sd652032874;
  localparam logic signed [30:0] TurnPerRad = 31'sd683565276;

  // CORDIC datapath width: Q2.30 plus guard
  localparam int CW = 34;

  typedef logic signed [CW-1:0] cval_t;

  // arctangent of 2^-i as binary angle
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
    logic        [15:0] dt_ticks;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading;
  } out_word_t;

  // token handed along the CORDIC row
  typedef struct packed {
    logic        vld;
    cval_t       x;
    cval_t       y;
    logic signed [32:0] z;
  } cell_tok_t;

endpackage

### design/poi_if.sv
// ----------------------------------------------------------------------------
// poi_in_if / poi_out_if
// Valid/ready channels carrying one input word and one pose word.
// ----------------------------------------------------------------------------
interface poi_in_if;
  import poi_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface poi_out_if;
  import poi_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/poi_cell.sv
// ----------------------------------------------------------------------------
// poi_cell
// One CORDIC micro-rotation by a fixed shift, registered toward its neighbor.
// ----------------------------------------------------------------------------
module poi_cell #(
  parameter int Shift = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  poi_pkg::cell_tok_t tok_in,
  output poi_pkg::cell_tok_t tok_out
);
  import poi_pkg::*;

  localparam logic [31:0] Atan = atan_lut(5'(Shift));

  cell_tok_t tok_next;

  // rotate toward zero residual angle
  always_comb begin
    tok_next     = tok_in;
    if (tok_in.z >= 0) begin
      tok_next.x = tok_in.x - (tok_in.y >>> Shift);
      tok_next.y = tok_in.y + (tok_in.x >>> Shift);
      tok_next.z = tok_in.z - $signed({1'b0, Atan});
    end else begin
      tok_next.x = tok_in.x + (tok_in.y >>> Shift);
      tok_next.y = tok_in.y - (tok_in.x >>> Shift);
      tok_next.z = tok_in.z + $signed({1'b0, Atan});
    end
  end

  // hand to neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
    tok_out.x <= tok_next.x;
    tok_out.y <= tok_next.y;
    tok_out.z <= tok_next.z;
  end

endmodule

### design/poi_cordic_row.sv
// ----------------------------------------------------------------------------
// poi_cordic_row
// Chain of CORDIC cells, one per step, producing cosine and sine in Q2.30.
// ----------------------------------------------------------------------------
module poi_cordic_row #(
  parameter int CordicSteps = poi_pkg::CordicStepsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  poi_pkg::cell_tok_t tok_in,
  output poi_pkg::cell_tok_t tok_out
);
  import poi_pkg::*;

  localparam int Used = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;

  cell_tok_t link [Used+1];

  assign link[0] = tok_in;

  // build the row
  for (genvar g = 0; g < Used; g++) begin : g_cell
    poi_cell #(.Shift(g)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (link[g]),
      .tok_out(link[g+1])
    );
  end

  assign tok_out = link[Used];

endmodule

### design/planar_odometry_integrator.sv
// ----------------------------------------------------------------------------
// planar_odometry_integrator
// Dead-reckoning 2D pose integration with a CORDIC cell row.
// ----------------------------------------------------------------------------
// Usage: in_ch takes one word of body velocities and a time step; out_ch
// returns the pose after that update. One word is in flight at a time.
// From acceptance to out_ch valid, the word enters the first CORDIC cell at
// acceptance and is registered through each remaining cell; then the quadrant
// is unfolded, the multiply/accumulate states StM0 to StM3 run on the shared
// 34x32 multiplier, and the heading is updated.
// A new word is accepted once the previous pose word has been taken; the
// pose register stays in the output stage, so a stalled receiver simply
// holds out_ch valid and in_ch not ready.
// Reset (synchronous, rst high) clears position and heading to zero and
// drops any word in flight.
// ----------------------------------------------------------------------------
module planar_odometry_integrator #(
  parameter int CORDIC_STEPS = poi_pkg::CordicStepsDefault
) (
  input logic      clk,
  input logic      rst,
  poi_in_if.sink   in_ch,
  poi_out_if.source out_ch
);
  import poi_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRot  = 3'd1;
  localparam logic [2:0] StM0   = 3'd2;
  localparam logic [2:0] StM1   = 3'd3;
  localparam logic [2:0] StM2   = 3'd4;
  localparam logic [2:0] StM3   = 3'd5;
  localparam logic [2:0] StFin  = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  logic [2:0]         state;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [31:0]        pose_heading;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] yp;
  logic [1:0]         quad;
  cval_t              c;
  cval_t              s;
  logic signed [66:0] acc;
  logic signed [66:0] wx;
  logic signed [63:0] prod;
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  cell_tok_t          row_in;
  cell_tok_t          row_out;

  logic [1:0]         q_next;
  logic [31:0]        r_ang;

  // fold heading to nearest quarter turn
  always_comb begin
    q_next = 2'(((pose_heading + 32'h2000_0000) >> 30));
    r_ang  = pose_heading - {q_next, 30'd0};
  end

  assign row_in.vld = (state == StIdle) && in_ch.valid;
  assign row_in.x   = CW'(GainQ30);
  assign row_in.y   = '0;
  assign row_in.z   = {r_ang[31], r_ang};

  poi_cordic_row #(.CordicSteps(CORDIC_STEPS)) u_row (
    .clk    (clk),
    .rst    (rst),
    .tok_in (row_in),
    .tok_out(row_out)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = c;
    mul_b = dx;
    unique case (state)
      StM0:    begin mul_a = c; mul_b = dx; end
      StM1:    begin mul_a = -s; mul_b = dy; end
      StM2:    begin mul_a = s; mul_b = dx; end
      StM3:    begin mul_a = c; mul_b = dy; end
      StFin:   begin mul_a = 34'(TurnPerRad); mul_b = yp; end
      default: begin mul_a = c; mul_b = dx; end
    endcase
    prod = 64'(mul_a) * 64'(mul_b);
  end

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                 input logic signed [66:0] w);
    logic signed [67:0] t;
    t = 68'(p) + 68'(w >>> 44);
    if (t > 68'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (t < -68'sh8000_0000) return 32'sh8000_0000;
    return t[31:0];
  endfunction

  assign in_ch.ready = (state == StIdle);
  assign out_ch.valid = (state == StOut);
  assign out_ch.data  = '{pos_x: pose_x, pos_y: pose_y, heading: pose_heading};

  // sequence one word through rotation and accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= StIdle;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
    end else begin
      unique case (state)
        StIdle: if (in_ch.valid) begin
          dx    <= 32'(in_ch.data.vel_x) * 32'($signed({1'b0, in_ch.data.dt_ticks}));
          dy    <= 32'(in_ch.data.vel_y) * 32'($signed({1'b0, in_ch.data.dt_ticks}));
          yp    <= 32'(in_ch.data.yaw_rate) * 32'($signed({1'b0, in_ch.data.dt_ticks}));
          quad  <= q_next;
          state <= StRot;
        end
        StRot: if (row_out.vld) begin
          unique case (quad)
            2'd0: begin c <= row_out.x;  s <= row_out.y;  end
            2'd1: begin c <= -row_out.y; s <= row_out.x;  end
            2'd2: begin c <= -row_out.x; s <= -row_out.y; end
            default: begin c <= row_out.y; s <= -row_out.x; end
          endcase
          state <= StM0;
        end
        StM0: begin acc <= 67'(prod) + (67'sd1 <<< 43); state <= StM1; end
        StM1: begin wx <= acc + 67'(prod); state <= StM2; end
        StM2: begin acc <= 67'(prod) + (67'sd1 <<< 43); state <= StM3; end
        StM3: begin
          pose_x <= sat_add(pose_x, wx);
          pose_y <= sat_add(pose_y, acc + 67'(prod));
          state  <= StFin;
        end
        StFin: begin
          pose_heading <= pose_heading + 32'((prod + (64'sd1 <<< 31)) >>> 32);
          state        <= StOut;
        end
        StOut: if (out_ch.ready) state <= StIdle;
        default: state <= StIdle;
      endcase
    end
  end

  // at most one word on the row, and only while rotating
  a_row_busy: assert property (@(posedge clk) disable iff (rst)
    row_out.vld |-> (state == StRot)) else $error("row word outside rotate");
  a_hold_pose: assert property (@(posedge clk) disable iff (rst)
    (state == StOut && !out_ch.ready) |=> (state == StOut && $stable(pose_x)))
    else $error("pose moved under stall");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != StIdle) |-> !in_ch.ready) else $error("accept while busy");

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the planar odometry integrator. Body velocity words
// go in over a valid/ready channel. A local pose tracker with its own CORDIC
// computes each expected pose, and every pose word that comes out is checked
// against it. The run has a directed part, a full-speed stretch and a random
// part. Both channel sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  import poi_pkg::*;

  localparam int Steps      = CordicStepsDefault;
  localparam int IdleLimit  = 5000;
  localparam int SatItems   = 30;
  localparam int RandItems  = 480;
  localparam int SettleCyc  = 40;

  typedef struct {
    in_word_t w;
    bit       drain;  // hold until every pose word has come back
  } vel_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  poi_in_if  in_ch ();
  poi_out_if out_ch ();

  planar_odometry_integrator uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // binary-angle arctangent of 2^-i
  longint atan_ba [30] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
    'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
    'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
    'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
    'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
    'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
  };

  // tracked pose
  logic signed [31:0] trk_x;
  logic signed [31:0] trk_y;
  logic        [31:0] trk_hdg;

  vel_req_t  vel_q [$];
  out_word_t pose_q [$];

  int errors    = 0;
  int n_in      = 0;
  int n_out     = 0;
  int n_sat     = 0;
  int n_wrap    = 0;
  int idle_cnt  = 0;
  bit all_sent  = 1'b0;

  // cosine and sine of a binary angle, Q2.30
  function automatic void trig_q30(input logic [31:0] ang, output longint c,
                                   output longint s);
    logic [31:0] shifted;
    logic [1:0]  q;
    logic [31:0] r;
    longint      x, y, z, t;
    shifted = ang + 32'h2000_0000;
    q = shifted[31:30];
    r = ang - {q, 30'b0};
    z = longint'($signed(r));
    x = 652032874;
    y = 0;
    for (int i = 0; i < Steps && i < 30; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_ba[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_ba[i];
      end
      x = t;
    end
    case (q)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // advance the tracked pose by one velocity word
  function automatic out_word_t integrate_pose(input in_word_t w);
    longint dx, dy, p, c, s, wx, wy, nx, ny, dang;
    logic [32:0] hsum;
    out_word_t o;
    dx = longint'(w.vel_x) * longint'({1'b0, w.dt_ticks});
    dy = longint'(w.vel_y) * longint'({1'b0, w.dt_ticks});
    p  = longint'(w.yaw_rate) * longint'({1'b0, w.dt_ticks});
    trig_q30(trk_hdg, c, s);
    wx = (dx * c - dy * s + (64'sd1 <<< 43)) >>> 44;
    wy = (dx * s + dy * c + (64'sd1 <<< 43)) >>> 44;
    nx = longint'(trk_x) + wx;
    ny = longint'(trk_y) + wy;
    if (nx != longint'(clamp32(nx)) || ny != longint'(clamp32(ny))) n_sat++;
    trk_x = clamp32(nx);
    trk_y = clamp32(ny);
    dang = (p * 64'sd683565276 + (64'sd1 <<< 31)) >>> 32;
    hsum = {1'b0, trk_hdg} + {1'b0, dang[31:0]};
    if (hsum[32]) n_wrap++;
    trk_hdg = hsum[31:0];
    o.pos_x = trk_x;
    o.pos_y = trk_y;
    o.heading = trk_hdg;
    return o;
  endfunction

  function automatic void add_word(input logic [15:0] vx, input logic [15:0] vy,
                                   input logic [15:0] wz, input logic [15:0] dt,
                                   input bit drain);
    vel_req_t r;
    r.w.vel_x = vx;
    r.w.vel_y = vy;
    r.w.yaw_rate = wz;
    r.w.dt_ticks = dt;
    r.drain = drain;
    vel_q.push_back(r);
  endfunction

  // driver: bursts of words separated by random gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    int pending;
    vel_req_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      gap_left = 0;
      burst_left = $urandom_range(1, 20);
    end else begin
      pending = pose_q.size();
      if (in_ch.valid && in_ch.ready) begin
        pose_q.push_back(integrate_pose(in_ch.data));
        pending = pose_q.size();
        n_in++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the word until taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (vel_q.size() != 0 && !(vel_q[0].drain && pending != 0)) begin
        nxt = vel_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.data  <= nxt.w;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern and pose check
  int stall_left = 0;
  int run_left = 0;
  always @(posedge clk) begin
    out_word_t exp_pose;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_out++;
        if (pose_q.size() == 0) begin
          $error("pose word with nothing expected: %h", out_ch.data);
          errors++;
        end else begin
          exp_pose = pose_q.pop_front();
          if (out_ch.data.pos_x !== exp_pose.pos_x) begin
            $error("pos_x expected %0d actual %0d", exp_pose.pos_x, out_ch.data.pos_x);
            errors++;
          end
          if (out_ch.data.pos_y !== exp_pose.pos_y) begin
            $error("pos_y expected %0d actual %0d", exp_pose.pos_y, out_ch.data.pos_y);
            errors++;
          end
          if (out_ch.data.heading !== exp_pose.heading) begin
            $error("heading expected %h actual %h", exp_pose.heading,
                   out_ch.data.heading);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        out_ch.ready <= 1'b1;
      end else begin
        run_left = $urandom_range(0, 60);
        stall_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 40);
        out_ch.ready <= (stall_left == 0);
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cnt <= 0;
    end else if (!all_sent || pose_q.size() != 0) begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    trk_x = '0;
    trk_y = '0;
    trk_hdg = '0;

    // directed: zeros, extremes, zero step, quarter turns and wrap
    add_word(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 1'b0);
    add_word(16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    add_word(16'h8000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    add_word(16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b0);
    add_word(16'h0000, 16'h8000, 16'h0000, 16'hFFFF, 1'b0);
    add_word(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 1'b0);
    add_word(16'h0001, 16'hFFFF, 16'h0001, 16'h0001, 1'b0);
    for (int i = 0; i < 8; i++)
      add_word(16'h4000, 16'h2000, 16'h7FFF, 16'hFFFF, 1'b0);
    add_word(16'h1234, 16'hEDCB, 16'h0000, 16'h8000, 1'b1);
    for (int i = 0; i < 6; i++)
      add_word(16'hC000, 16'h3000, 16'h8000, 16'hFFFF, 1'b0);
    add_word(16'h5555, 16'hAAAA, 16'h5555, 16'h0000, 1'b0);

    // full speed for a stretch of largest steps
    for (int i = 0; i < SatItems; i++)
      add_word(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 1'b0);
    // and back again
    for (int i = 0; i < 10; i++)
      add_word(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b0);

    // random: mostly full range, some small steps, some zero steps
    for (int i = 0; i < RandItems; i++) begin
      case ($urandom_range(0, 5))
        0: add_word(16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom_range(0, 255)), i == RandItems / 2);
        1: add_word(16'($urandom), 16'($urandom), 16'($urandom), 16'h0000, 1'b0);
        default: add_word(16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), i == RandItems / 2);
      endcase
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    wait (vel_q.size() == 0 && !in_ch.valid);
    all_sent = 1'b1;
    wait (pose_q.size() == 0);
    repeat (SettleCyc) @(posedge clk);

    $display("covered %0d velocity words, %0d pose words checked", n_in, n_out);
    $display("saturating updates %0d, heading wraps %0d", n_sat, n_wrap);
    if (errors == 0 && pose_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
